[rtl/core/tcw_pkg.sv]
// shared types and constants for the text console writer
package tcw_pkg;

  localparam int unsigned COL_W  = 7;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned ADDR_W = 13;
  localparam int unsigned CNT_W  = 14;

  localparam logic [2:0] REQ_STREAM = 3'd0;
  localparam logic [2:0] REQ_WRITE  = 3'd1;
  localparam logic [2:0] REQ_SET    = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_READ   = 3'd4;

  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_MAXPOS = 8'h7F;

  typedef enum logic [2:0] {
    OP_CR,
    OP_LF,
    OP_PUT,
    OP_WRITE,
    OP_SET,
    OP_CLEAR,
    OP_READ,
    OP_REJECT
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_COPY,
    ST_READ
  } state_e;

  typedef struct packed {
    op_e               op;
    logic [7:0]        ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [ADDR_W-1:0] addr;
  } cmd_t;

endpackage

[rtl/core/tcw_if.sv]
// request and response channel interfaces
interface tcw_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] char_code;
  logic [7:0] col;
  logic [7:0] row;

  modport source (output valid, output req_type, output char_code, output col, output row,
                  input ready);
  modport sink (input valid, input req_type, input char_code, input col, input row,
                output ready);
endinterface

interface tcw_rsp_if;
  logic       valid;
  logic       ready;
  logic       status;
  logic [6:0] cursor_col;
  logic [5:0] cursor_row;
  logic [7:0] data_out;

  modport source (output valid, output status, output cursor_col, output cursor_row,
                  output data_out, input ready);
  modport sink (input valid, input status, input cursor_col, input cursor_row,
                input data_out, output ready);
endinterface

[rtl/core/tcw_front.sv]
// request intake: range checks and decode into commands
module tcw_front #(
  parameter int unsigned COLUMNS = 32,
  parameter int unsigned ROWS    = 14
) (
  tcw_req_if.sink        req_i,
  input  logic           init_busy_i,
  output logic           push_valid_o,
  output tcw_pkg::cmd_t  push_cmd_o,
  input  logic           push_ready_i
);
  import tcw_pkg::*;

  logic              in_range;
  logic [ADDR_W-1:0] addr;
  op_e               op;

  assign in_range = ({1'b0, req_i.col} < 9'(COLUMNS)) && ({1'b0, req_i.row} < 9'(ROWS));
  assign addr     = ADDR_W'(req_i.row[ROW_W-1:0]) * ADDR_W'(COLUMNS)
                  + ADDR_W'(req_i.col[COL_W-1:0]);

  always_comb begin
    unique case (req_i.req_type)
      REQ_STREAM: begin
        if (req_i.char_code == CH_CR) begin
          op = OP_CR;
        end else if (req_i.char_code == CH_LF) begin
          op = OP_LF;
        end else begin
          op = OP_PUT;
        end
      end
      REQ_WRITE: op = (in_range && req_i.char_code <= CH_MAXPOS) ? OP_WRITE : OP_REJECT;
      REQ_SET:   op = in_range ? OP_SET : OP_REJECT;
      REQ_CLEAR: op = OP_CLEAR;
      REQ_READ:  op = in_range ? OP_READ : OP_REJECT;
      default:   op = OP_REJECT;
    endcase
  end

  assign req_i.ready     = push_ready_i && !init_busy_i;
  assign push_valid_o    = req_i.valid && !init_busy_i;
  assign push_cmd_o.op   = op;
  assign push_cmd_o.ch   = req_i.char_code;
  assign push_cmd_o.col  = req_i.col[COL_W-1:0];
  assign push_cmd_o.row  = req_i.row[ROW_W-1:0];
  assign push_cmd_o.addr = addr;

endmodule

[rtl/core/tcw_queue.sv]
// two-entry command queue between intake and execution
module tcw_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  tcw_pkg::cmd_t push_cmd_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output tcw_pkg::cmd_t pop_cmd_o,
  input  logic          pop_i
);
  import tcw_pkg::*;

  cmd_t       entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_cmd_o    = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q + 1'b1;
    rd_ptr_d = rd_ptr_q + 1'b1;
    count_d  = count_q;
    if (!push) begin
      wr_ptr_d = wr_ptr_q;
    end
    if (!pop_i) begin
      rd_ptr_d = rd_ptr_q;
    end
    if (push && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (!push && pop_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_cmd_i;
    end
  end

endmodule

[rtl/core/tcw_back.sv]
// command execution: character store, cursor, sweeps and response register
module tcw_back #(
  parameter int unsigned COLUMNS = 32,
  parameter int unsigned ROWS    = 14
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_valid_i,
  input  tcw_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          init_busy_o,
  tcw_rsp_if.source     rsp_o
);
  import tcw_pkg::*;

  localparam int unsigned CELLS = COLUMNS * ROWS;
  localparam int unsigned AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned LAST  = CELLS - 1;

  logic [7:0]        store_mem [CELLS];
  logic [7:0]        rdata_q;

  state_e            state_q, state_d;
  logic [COL_W-1:0]  cur_col_q, cur_col_d;
  logic [ROW_W-1:0]  cur_row_q, cur_row_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [CNT_W-1:0]  rd_q, rd_d;
  logic              pend_q, pend_d;
  logic              init_q, init_d;
  logic [ADDR_W-1:0] pdst_q, pdst_d;
  logic [ADDR_W-1:0] off_q, off_d;
  logic              shift_q, shift_d;
  logic [7:0]        ch_q, ch_d;

  logic              ov_q, ov_d;
  logic              ostat_q, ostat_d;
  logic [COL_W-1:0]  ocol_q, ocol_d;
  logic [ROW_W-1:0]  orow_q, orow_d;
  logic [7:0]        odata_q, odata_d;

  logic              pop;
  logic              at_last;
  logic              last_row;
  logic              load;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [7:0]        wdata;
  logic [ADDR_W-1:0] raddr;
  logic [ADDR_W-1:0] cur_idx;
  logic              copy_done;

  assign last_row  = (cur_row_q == ROW_W'(ROWS - 1));
  assign at_last   = last_row && (cur_col_q == COL_W'(COLUMNS - 1));
  assign cur_idx   = ADDR_W'(cur_row_q) * ADDR_W'(COLUMNS) + ADDR_W'(cur_col_q);
  assign pop       = (state_q == ST_IDLE) && cmd_valid_i && (!ov_q || rsp_o.ready);
  assign copy_done = (rd_q == CNT_W'(CELLS)) && !pend_q;

  assign cmd_pop_o        = pop;
  assign init_busy_o      = init_q;
  assign rsp_o.valid      = ov_q;
  assign rsp_o.status     = ostat_q;
  assign rsp_o.cursor_col = ocol_q;
  assign rsp_o.cursor_row = orow_q;
  assign rsp_o.data_out   = odata_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          unique case (cmd_i.op)
            OP_LF:    state_d = last_row ? ST_COPY : ST_IDLE;
            OP_PUT:   state_d = at_last ? ST_COPY : ST_IDLE;
            OP_CLEAR: state_d = ST_CLEAR;
            OP_READ:  state_d = ST_READ;
            default:  state_d = ST_IDLE;
          endcase
        end
      end
      ST_CLEAR: begin
        if (cnt_q == CNT_W'(LAST)) begin
          state_d = ST_IDLE;
        end
      end
      ST_COPY: begin
        if (copy_done) begin
          state_d = ST_IDLE;
        end
      end
      ST_READ: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    we        = 1'b0;
    waddr     = cur_idx;
    wdata     = cmd_i.ch;
    raddr     = ADDR_W'(rd_q);
    cur_col_d = cur_col_q;
    cur_row_d = cur_row_q;
    cnt_d     = cnt_q;
    rd_d      = rd_q;
    pend_d    = pend_q;
    init_d    = init_q;
    pdst_d    = pdst_q;
    off_d     = off_q;
    shift_d   = shift_q;
    ch_d      = ch_q;
    load      = 1'b0;
    ostat_d   = 1'b0;
    odata_d   = 8'h00;

    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          ch_d = cmd_i.ch;
          unique case (cmd_i.op)
            OP_CR: begin
              cur_col_d = '0;
              load      = 1'b1;
              odata_d   = cmd_i.ch;
            end
            OP_LF: begin
              load    = 1'b1;
              odata_d = cmd_i.ch;
              if (!last_row) begin
                cur_col_d = '0;
                cur_row_d = cur_row_q + ROW_W'(1);
              end else begin
                rd_d    = CNT_W'(COLUMNS);
                off_d   = ADDR_W'(COLUMNS);
                shift_d = 1'b0;
                pend_d  = 1'b0;
              end
            end
            OP_PUT: begin
              load    = 1'b1;
              odata_d = cmd_i.ch;
              if (at_last) begin
                rd_d    = CNT_W'(1);
                off_d   = ADDR_W'(1);
                shift_d = 1'b1;
                pend_d  = 1'b0;
              end else begin
                we = 1'b1;
                if (cur_col_q == COL_W'(COLUMNS - 1)) begin
                  cur_col_d = '0;
                  cur_row_d = last_row ? cur_row_q : cur_row_q + ROW_W'(1);
                end else begin
                  cur_col_d = cur_col_q + COL_W'(1);
                end
              end
            end
            OP_WRITE: begin
              we    = 1'b1;
              waddr = cmd_i.addr;
              load  = 1'b1;
            end
            OP_SET: begin
              cur_col_d = cmd_i.col;
              cur_row_d = cmd_i.row;
              load      = 1'b1;
            end
            OP_CLEAR: begin
              cnt_d = '0;
              load  = 1'b1;
            end
            OP_READ: begin
              raddr = cmd_i.addr;
            end
            OP_REJECT: begin
              load    = 1'b1;
              ostat_d = 1'b1;
            end
            default: begin
              load    = 1'b1;
              ostat_d = 1'b1;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        we    = 1'b1;
        waddr = ADDR_W'(cnt_q);
        wdata = CH_SPACE;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(LAST)) begin
          init_d = 1'b0;
        end
      end
      ST_COPY: begin
        if (pend_q) begin
          we    = 1'b1;
          waddr = pdst_q;
          wdata = rdata_q;
        end
        if (rd_q < CNT_W'(CELLS)) begin
          raddr  = ADDR_W'(rd_q);
          pdst_d = ADDR_W'(rd_q) - off_q;
          pend_d = 1'b1;
          rd_d   = rd_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
        end
        if (copy_done && shift_q) begin
          we    = 1'b1;
          waddr = ADDR_W'(LAST);
          wdata = ch_q;
        end
      end
      ST_READ: begin
        load    = 1'b1;
        odata_d = rdata_q;
      end
      default: begin
      end
    endcase

    ocol_d = load ? cur_col_d : ocol_q;
    orow_d = load ? cur_row_d : orow_q;
    if (!load) begin
      ostat_d = ostat_q;
      odata_d = odata_q;
    end
    ov_d = (ov_q && !rsp_o.ready) || load;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      cur_col_q <= '0;
      cur_row_q <= '0;
      cnt_q     <= '0;
      rd_q      <= '0;
      pend_q    <= 1'b0;
      init_q    <= 1'b1;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      cur_col_q <= cur_col_d;
      cur_row_q <= cur_row_d;
      cnt_q     <= cnt_d;
      rd_q      <= rd_d;
      pend_q    <= pend_d;
      init_q    <= init_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pdst_q  <= pdst_d;
    off_q   <= off_d;
    shift_q <= shift_d;
    ch_q    <= ch_d;
    ostat_q <= ostat_d;
    ocol_q  <= ocol_d;
    orow_q  <= orow_d;
    odata_q <= odata_d;
  end

  // character store
  always_ff @(posedge clk_i) begin
    if (we) begin
      store_mem[waddr[AW-1:0]] <= wdata;
    end
    rdata_q <= store_mem[raddr[AW-1:0]];
  end

  a_cursor_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, cur_col_q} < (COL_W + 1)'(COLUMNS)) && ({1'b0, cur_row_q} < (ROW_W + 1)'(ROWS)))
    else $error("cursor out of range");

  a_copy_keeps_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_COPY) |=> ($stable(cur_col_q) && $stable(cur_row_q)))
    else $error("cursor moved during store copy");

  a_pend_in_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (state_q == ST_COPY))
    else $error("pending copy read outside copy");

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_READ) |-> !ov_q)
    else $error("read result would overwrite pending response");

endmodule

[rtl/core/text_console_writer.sv]
// text console writer top level
//
// A ROWS by COLUMNS character store with a cursor. Requests come in on
// req_i (stream a character, write at a position, set the cursor, clear,
// read a cell); each request gives exactly one response on rsp_o with a
// status, the cursor after the request and the streamed or read character.
// Intake decodes requests into a two-entry queue; execution takes one
// command at a time and holds its response in an output register, so
// the intake keeps taking requests while a response waits on the sink.
// Plain requests complete one per cycle while the response sink keeps
// up; a cell read passes through a read state for the registered store
// read. A clear, a scroll on line feed and a streamed character at the
// last cell sweep the store through its single write port and hold off
// further commands until done. After reset the store is filled with
// spaces, with req_i.ready low until it is done; the cursor resets to
// the top left. A stalled response sink holds the response and, once
// the queue is full, stalls req_i.
module text_console_writer #(
  parameter int unsigned COLUMNS = 32,
  parameter int unsigned ROWS    = 14
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  tcw_req_if.sink   req_i,
  tcw_rsp_if.source rsp_o
);
  import tcw_pkg::*;

  logic init_busy;
  logic push_valid;
  logic push_ready;
  cmd_t push_cmd;
  logic cmd_valid;
  cmd_t cmd;
  logic cmd_pop;

  tcw_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .req_i        (req_i),
    .init_busy_i  (init_busy),
    .push_valid_o (push_valid),
    .push_cmd_o   (push_cmd),
    .push_ready_i (push_ready)
  );

  tcw_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_cmd_i   (push_cmd),
    .push_ready_o (push_ready),
    .pop_valid_o  (cmd_valid),
    .pop_cmd_o    (cmd),
    .pop_i        (cmd_pop)
  );

  tcw_back #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .init_busy_o (init_busy),
    .rsp_o       (rsp_o)
  );

endmodule
